// ----- src/lfps_pkg.sv -----
// Shared types, constants, the line lookup and the speed clamp function for the line-follow PID steering block.
`default_nettype none
package lfps_pkg;

    localparam int NumSensors   = 8;
    localparam int ReadingWidth = 10;
    localparam int GainWidth    = 16;
    localparam int SpeedWidth   = 8;
    localparam int ErrWidth     = 5;
    localparam int IntegWidth   = 16;
    localparam int DiffWidth    = ErrWidth + 1;
    localparam int CfgIdxWidth  = 3;

    // Product and sum widths of the PID datapath
    localparam int ProdPWidth = GainWidth + 1 + ErrWidth;
    localparam int ProdIWidth = GainWidth + 1 + IntegWidth;
    localparam int ProdDWidth = GainWidth + 1 + DiffWidth;
    localparam int SumWidth   = ProdIWidth + 2;
    localparam int TermWidth  = SumWidth - 8;
    localparam int SpeedFull  = TermWidth + 1;
    localparam int ClampWidth = SpeedWidth + 1;

    localparam int SpeedLimit = 255;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CfgThreshold = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgGainP     = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgGainI     = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgGainD     = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgBase      = 3'd4;

    // Register reset values
    localparam logic [ReadingWidth-1:0] ThresholdReset = 10'd50;
    localparam logic [GainWidth-1:0]    GainPReset     = 16'd2560;
    localparam logic [GainWidth-1:0]    GainIReset     = 16'd26;
    localparam logic [GainWidth-1:0]    GainDReset     = 16'd0;
    localparam logic [SpeedWidth-1:0]   BaseReset      = 8'd170;

    typedef logic signed [ErrWidth-1:0] err_t;

    typedef struct packed {
        logic hit;
        err_t err;
    } lookup_t;

    // Stage-one request: error, updated integral and difference
    typedef struct packed {
        err_t                          err;
        logic signed [IntegWidth-1:0]  integ;
        logic signed [DiffWidth-1:0]   diff;
    } track_t;

    // Motor command handed to the output port
    typedef struct packed {
        logic                  drive_valid;
        logic                  right_reverse;
        logic [SpeedWidth-1:0] right_magnitude;
        logic                  left_reverse;
        logic [SpeedWidth-1:0] left_magnitude;
        err_t                  position_error;
    } drive_t;

    // Known line patterns and their position error
    function automatic lookup_t line_lookup(input logic [NumSensors-1:0] pattern);
        lookup_t res;
        res.hit = 1'b1;
        res.err = 5'sd0;
        unique case (pattern)
            8'h00: res.err = 5'sd0;
            8'h08: res.err = -5'sd1;
            8'h0C: res.err = -5'sd2;
            8'h04: res.err = -5'sd3;
            8'h06: res.err = -5'sd4;
            8'h02: res.err = -5'sd5;
            8'h43: res.err = -5'sd6;
            8'h07: res.err = -5'sd7;
            8'h10: res.err = 5'sd1;
            8'h30: res.err = 5'sd2;
            8'h20: res.err = 5'sd3;
            8'h6F: res.err = 5'sd4;
            8'h40: res.err = 5'sd5;
            8'hC0: res.err = 5'sd6;
            8'h80: res.err = 5'sd7;
            8'h0F: res.err = -5'sd10;
            8'hF0: res.err = 5'sd10;
            default: res.hit = 1'b0;
        endcase
        return res;
    endfunction

    // Clamp a wheel speed to +/- SpeedLimit
    function automatic logic signed [ClampWidth-1:0] clamp_speed(
        input logic signed [SpeedFull-1:0] v
    );
        logic signed [ClampWidth-1:0] res;
        res = v[ClampWidth-1:0];
        if (v > SpeedFull'(SpeedLimit))
            res = ClampWidth'(SpeedLimit);
        else if (v < -SpeedFull'(SpeedLimit))
            res = -ClampWidth'(SpeedLimit);
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- src/line_follow_pid_steering.sv -----
// Throughput: one request per cycle unless the output is back-pressured. The error
//   lookup and saturating integral update close their loop in the merge stage; the
//   products, term and clamp are three further pipeline stages, each with its own
//   valid and ready, and a result is presented from the output register.
// Reset: rst_n clears the pipeline valids, held error and integral, and loads
//   the configuration registers with their defaults.
`default_nettype none
module line_follow_pid_steering (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: sensor_left_3[9:0], sensor_left_2[19:10], sensor_left_1[29:20],
    //   sensor_left_0[39:30], sensor_right_0[49:40], sensor_right_1[59:50],
    //   sensor_right_2[69:60], sensor_right_3[79:70]
    input  wire logic [79:0] s_tdata,
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: position_error[4:0], left_magnitude[12:5], left_reverse[13],
    //   right_magnitude[21:14], right_reverse[22], zero[23]
    output logic [23:0]      m_tdata,
    // m_tuser: drive_valid[0]
    output logic             m_tuser
);
    import lfps_pkg::*;

    logic [ReadingWidth-1:0] threshold_reg;
    logic [GainWidth-1:0]    gain_p_reg;
    logic [GainWidth-1:0]    gain_i_reg;
    logic [GainWidth-1:0]    gain_d_reg;
    logic [SpeedWidth-1:0]   base_reg;

    logic [NumSensors-1:0]   line_bits;
    track_t                  track;
    drive_t                  drive;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic accept;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ThresholdReset;
            gain_p_reg    <= GainPReset;
            gain_i_reg    <= GainIReset;
            gain_d_reg    <= GainDReset;
            base_reg      <= BaseReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CfgThreshold: threshold_reg <= cfg_data[ReadingWidth-1:0];
                CfgGainP:     gain_p_reg    <= cfg_data;
                CfgGainI:     gain_i_reg    <= cfg_data;
                CfgGainD:     gain_d_reg    <= cfg_data;
                CfgBase:      base_reg      <= cfg_data[SpeedWidth-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline handshake: a stage loads when it is empty or drains downstream
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Sensor lanes
    for (genvar g = 0; g < NumSensors; g++)
    begin : g_lane
        lfps_lane u_lane (
            .reading   (s_tdata[g*ReadingWidth +: ReadingWidth]),
            .threshold (threshold_reg),
            .line_bit  (line_bits[g])
        );
    end

    lfps_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_bits (line_bits),
        .accept    (accept),
        .track     (track)
    );

    lfps_pid u_pid (
        .clk        (clk),
        .track      (track),
        .gain_p     (gain_p_reg),
        .gain_i     (gain_i_reg),
        .gain_d     (gain_d_reg),
        .base_speed (base_reg),
        .load_prod  (v1_reg && rdy2),
        .load_term  (v2_reg && rdy3),
        .load_out   (v3_reg && rdy4),
        .drive      (drive)
    );

    // Output port
    assign m_tvalid = v4_reg;
    assign m_tdata  = {1'b0, drive.right_reverse, drive.right_magnitude,
                       drive.left_reverse, drive.left_magnitude, drive.position_error};
    assign m_tuser  = drive.drive_valid;

    // Input stalls only when the output holds a result that is not taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A valid drive command never carries a zero wheel magnitude
    a_drive_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[12:5] != 8'd0 && m_tdata[21:14] != 8'd0))
        else $error("drive command with zero magnitude");

    // Without a drive command the wheel fields are cleared
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[23:5] == 19'd0))
        else $error("wheel fields set without drive command");

    // A stalled result holds its position error
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata[4:0]))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- src/lfps_lane.sv -----
// One sensor lane: compares a calibrated reading against the line threshold.
`default_nettype none
module lfps_lane (
    input  wire logic [lfps_pkg::ReadingWidth-1:0] reading,
    input  wire logic [lfps_pkg::ReadingWidth-1:0] threshold,
    output logic                                   line_bit
);
    import lfps_pkg::*;

    // Sensor sees the line when strictly above threshold
    assign line_bit = (reading > threshold);

endmodule
`default_nettype wire

// ----- src/lfps_merge.sv -----
// Merge stage: pattern match of the lane bits, held error and saturating integral.
`default_nettype none
module lfps_merge (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [lfps_pkg::NumSensors-1:0] line_bits,
    input  wire logic                            accept,
    output lfps_pkg::track_t                     track
);
    import lfps_pkg::*;

    err_t                          held_error_reg;
    logic signed [IntegWidth-1:0]  integral_reg;
    logic signed [IntegWidth-1:0]  integral_next;
    track_t                        track_reg;
    lookup_t                       found;
    err_t                          err_now;
    logic signed [IntegWidth:0]    integ_sum;
    logic signed [DiffWidth-1:0]   diff_now;

    // Pattern lookup; unknown pattern keeps the last error
    always_comb
    begin
        found   = line_lookup(line_bits);
        err_now = found.hit ? found.err : held_error_reg;
    end

    // Integral with 16-bit saturation, and first difference
    always_comb
    begin
        integ_sum = {integral_reg[IntegWidth-1], integral_reg}
                  + {{(IntegWidth + 1 - ErrWidth){err_now[ErrWidth-1]}}, err_now};
        if (integ_sum[IntegWidth] != integ_sum[IntegWidth-1])
            integral_next = integ_sum[IntegWidth] ? {1'b1, {(IntegWidth-1){1'b0}}}
                                                  : {1'b0, {(IntegWidth-1){1'b1}}};
        else
            integral_next = integ_sum[IntegWidth-1:0];
        diff_now = {err_now[ErrWidth-1], err_now} - {held_error_reg[ErrWidth-1], held_error_reg};
    end

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_error_reg <= '0;
            integral_reg   <= '0;
        end
        else if (accept)
        begin
            held_error_reg <= err_now;
            integral_reg   <= integral_next;
        end
    end

    // Stage-one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            track_reg.err   <= err_now;
            track_reg.integ <= integral_next;
            track_reg.diff  <= diff_now;
        end
    end

    assign track = track_reg;

endmodule
`default_nettype wire

// ----- src/lfps_pid.sv -----
// PID datapath: gain products, truncated term, wheel speed clamp and output register.
`default_nettype none
module lfps_pid (
    input  wire logic                             clk,
    input  wire lfps_pkg::track_t                 track,
    input  wire logic [lfps_pkg::GainWidth-1:0]   gain_p,
    input  wire logic [lfps_pkg::GainWidth-1:0]   gain_i,
    input  wire logic [lfps_pkg::GainWidth-1:0]   gain_d,
    input  wire logic [lfps_pkg::SpeedWidth-1:0]  base_speed,
    input  wire logic                             load_prod,
    input  wire logic                             load_term,
    input  wire logic                             load_out,
    output lfps_pkg::drive_t                      drive
);
    import lfps_pkg::*;

    logic signed [ProdPWidth-1:0] prod_p_reg;
    logic signed [ProdIWidth-1:0] prod_i_reg;
    logic signed [ProdDWidth-1:0] prod_d_reg;
    err_t                         err2_reg;
    logic signed [TermWidth-1:0]  term_reg;
    err_t                         err3_reg;
    drive_t                       drive_reg;
    logic signed [SumWidth-1:0]   sum;
    logic signed [SumWidth-1:0]   sum_adj;
    logic signed [SpeedFull-1:0]  left_full;
    logic signed [SpeedFull-1:0]  right_full;
    logic signed [ClampWidth-1:0] left_c;
    logic signed [ClampWidth-1:0] right_c;
    logic [ClampWidth-1:0]        left_abs;
    logic [ClampWidth-1:0]        right_abs;
    logic                         valid_now;

    // Three gain products side by side
    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            prod_p_reg <= $signed({1'b0, gain_p}) * track.err;
            prod_i_reg <= $signed({1'b0, gain_i}) * track.integ;
            prod_d_reg <= $signed({1'b0, gain_d}) * track.diff;
            err2_reg   <= track.err;
        end
    end

    // Signed Q27.8 sum, divided by 256 toward zero
    always_comb
    begin
        sum = SumWidth'(prod_p_reg) + SumWidth'(prod_i_reg) + SumWidth'(prod_d_reg);
        sum_adj = sum[SumWidth-1] ? (sum + SumWidth'(255)) : sum;
    end

    always_ff @(posedge clk)
    begin
        if (load_term)
        begin
            term_reg <= sum_adj[SumWidth-1:8];
            err3_reg <= err2_reg;
        end
    end

    // Wheel speeds, clamp, sign and magnitude
    always_comb
    begin
        left_full  = $signed({{(SpeedFull - SpeedWidth){1'b0}}, base_speed})
                   + SpeedFull'(term_reg);
        right_full = $signed({{(SpeedFull - SpeedWidth){1'b0}}, base_speed})
                   - SpeedFull'(term_reg);
        left_c     = clamp_speed(left_full);
        right_c    = clamp_speed(right_full);
        left_abs   = left_c[ClampWidth-1] ? ClampWidth'(-left_c) : ClampWidth'(left_c);
        right_abs  = right_c[ClampWidth-1] ? ClampWidth'(-right_c) : ClampWidth'(right_c);
        valid_now  = (left_c != '0) && (right_c != '0);
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            drive_reg.position_error  <= err3_reg;
            drive_reg.drive_valid     <= valid_now;
            drive_reg.left_magnitude  <= valid_now ? left_abs[SpeedWidth-1:0] : '0;
            drive_reg.left_reverse    <= valid_now & left_c[ClampWidth-1];
            drive_reg.right_magnitude <= valid_now ? right_abs[SpeedWidth-1:0] : '0;
            drive_reg.right_reverse   <= valid_now & right_c[ClampWidth-1];
        end
    end

    assign drive = drive_reg;

endmodule
`default_nettype wire
